// File: src/fgr_pkg.sv
// Shared constants and state types for the fraction GCD reducer.
`timescale 1ns / 1ps
`default_nettype none

package fgr_pkg;

    // Arithmetic width; the 32-bit fields are truncated to it.
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int CALC_W      = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int CNT_W       = $clog2(CALC_W);

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(CALC_W - 1);

    // result status codes
    localparam logic STATUS_REDUCED  = 1'b0;
    localparam logic STATUS_ZERO_DEN = 1'b1;

    typedef enum logic [1:0] {
        G_IDLE,
        G_TWOS,
        G_REDUCE,
        G_RESTORE
    } gcd_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_GCD,
        T_DIV_NUM,
        T_DIV_DEN,
        T_FINISH
    } ctl_state_t;

endpackage

`default_nettype wire

// File: src/fgr_gcd.sv
// Binary GCD unit: one shift or one subtract-and-shift step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fgr_gcd
    import fgr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CALC_W-1:0] a_in,
    input  wire logic [CALC_W-1:0] b_in,
    output logic                   done,
    output logic [CALC_W-1:0]      gcd_out
);

    gcd_state_t        state_reg, state_next;
    logic [CALC_W-1:0] a_reg, a_next;
    logic [CALC_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              done_reg, done_next;
    logic [CALC_W-1:0] a_minus_b;
    logic [CALC_W-1:0] b_minus_a;

    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        case (state_reg)
            G_IDLE: begin
                if (start) begin
                    a_next     = a_in;
                    b_next     = b_in;
                    k_next     = '0;
                    state_next = G_TWOS;
                end
            end
            G_TWOS: begin
                // strip the common power of two, counted in k
                if (a_reg[0] || b_reg[0]) begin
                    state_next = G_REDUCE;
                end else begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            G_REDUCE: begin
                if (a_reg == '0) begin
                    state_next = G_RESTORE;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_reg >= b_reg) begin
                    a_next = a_minus_b >> 1;
                end else begin
                    b_next = b_minus_a >> 1;
                end
            end
            G_RESTORE: begin
                if (k_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = G_IDLE;
                end else begin
                    b_next = b_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end
            default: state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    assign done    = done_reg;
    assign gcd_out = b_reg;

endmodule

`default_nettype wire

// File: src/fgr_div.sv
// Restoring divider: one quotient bit per cycle, shifted in from the bottom.
`timescale 1ns / 1ps
`default_nettype none

module fgr_div
    import fgr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CALC_W-1:0] dividend,
    input  wire logic [CALC_W-1:0] divisor,
    output logic                   done,
    output logic [CALC_W-1:0]      quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CALC_W-1:0] rem_reg, rem_next;
    logic [CALC_W-1:0] quo_reg, quo_next;
    logic [CALC_W-1:0] dsr_reg;
    logic [CALC_W:0]   rem_shift;
    logic [CALC_W:0]   trial;

    assign rem_shift = {rem_reg, quo_reg[CALC_W-1]};
    assign trial     = rem_shift - {1'b0, dsr_reg};

    always_comb begin
        if (trial[CALC_W]) begin
            rem_next = rem_shift[CALC_W-1:0];
            quo_next = {quo_reg[CALC_W-2:0], 1'b0};
        end else begin
            rem_next = trial[CALC_W-1:0];
            quo_next = {quo_reg[CALC_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: src/fraction_gcd_reducer.sv
// Top level of the fraction GCD reducer: control sequencer and output register.
// Usage:
//   Input channel s_valid/s_ready carries one fraction (s_numerator,
//   s_denominator, unsigned). Output channel m_valid/m_ready returns the
//   reduced pair and m_status (1 = zero denominator, inputs passed through).
//   One item is worked on at a time; s_ready is high while the sequencer idles.
//   A zero numerator or zero denominator skips the GCD and goes straight to
//   the output load. Otherwise a binary GCD runs (k shared factors of two,
//   s reduce steps), then two restoring divisions that share one divider,
//   and then the output load. s_ready returns with m_valid.
//   The finished result sits in an output register, so the next item is taken
//   while m_ready is low; a second finished result waits until the first is
//   taken. Reset (aresetn low, synchronous) drops m_valid and returns the
//   sequencer to idle; any item in flight is discarded.
`timescale 1ns / 1ps
`default_nettype none

module fraction_gcd_reducer
    import fgr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [FIELD_W-1:0]  s_numerator,
    input  wire logic [FIELD_W-1:0]  s_denominator,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [FIELD_W-1:0]       m_reduced_numerator,
    output logic [FIELD_W-1:0]       m_reduced_denominator,
    output logic                     m_status
);

    ctl_state_t        state_reg, state_next;
    logic [CALC_W-1:0] num_in, den_in;
    logic [CALC_W-1:0] num_reg, den_reg, g_reg;
    logic [CALC_W-1:0] rn_reg, rd_reg;
    logic              st_reg;
    logic              m_valid_reg;
    logic [CALC_W-1:0] out_num_reg, out_den_reg;
    logic              out_st_reg;
    logic              accept, out_load;
    logic              gcd_start, gcd_done;
    logic [CALC_W-1:0] gcd_val;
    logic              div_start, div_done;
    logic [CALC_W-1:0] div_dividend, div_divisor, div_quo;

    assign num_in = s_numerator[CALC_W-1:0];
    assign den_in = s_denominator[CALC_W-1:0];

    assign s_ready   = (state_reg == T_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == T_FINISH) && (!m_valid_reg || m_ready);
    assign gcd_start = accept && (den_in != '0) && (num_in != '0);
    assign div_start = ((state_reg == T_GCD) && gcd_done) ||
                       ((state_reg == T_DIV_NUM) && div_done);

    // first division right after the GCD, second one with the held divisor
    assign div_dividend = (state_reg == T_GCD) ? num_reg : den_reg;
    assign div_divisor  = (state_reg == T_GCD) ? gcd_val : g_reg;

    fgr_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .a_in    (num_in),
        .b_in    (den_in),
        .done    (gcd_done),
        .gcd_out (gcd_val)
    );

    fgr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    state_next = gcd_start ? T_GCD : T_FINISH;
                end
            end
            T_GCD: begin
                if (gcd_done) state_next = T_DIV_NUM;
            end
            T_DIV_NUM: begin
                if (div_done) state_next = T_DIV_DEN;
            end
            T_DIV_DEN: begin
                if (div_done) state_next = T_FINISH;
            end
            T_FINISH: begin
                if (out_load) state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            num_reg <= num_in;
            den_reg <= den_in;
            st_reg  <= (den_in == '0) ? STATUS_ZERO_DEN : STATUS_REDUCED;
            if (den_in == '0) begin
                rn_reg <= num_in;
                rd_reg <= '0;
            end else if (num_in == '0) begin
                rn_reg <= '0;
                rd_reg <= CALC_W'(1);
            end
        end
        if ((state_reg == T_GCD) && gcd_done) begin
            g_reg <= gcd_val;
        end
        if ((state_reg == T_DIV_NUM) && div_done) begin
            rn_reg <= div_quo;
        end
        if ((state_reg == T_DIV_DEN) && div_done) begin
            rd_reg <= div_quo;
        end
        if (out_load) begin
            out_num_reg <= rn_reg;
            out_den_reg <= rd_reg;
            out_st_reg  <= st_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_reduced_numerator   = FIELD_W'(out_num_reg);
    assign m_reduced_denominator = FIELD_W'(out_den_reg);
    assign m_status              = out_st_reg;

    // zero-denominator flag and a zero denominator go together
    a_status_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == (m_reduced_denominator == '0)))
        else $error("status does not match denominator");

    // the GCD of two nonzero values is never zero
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (gcd_done && (state_reg == T_GCD)) |-> (gcd_val != '0))
        else $error("gcd unit returned zero");

    // divider completes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> ((state_reg == T_DIV_NUM) || (state_reg == T_DIV_DEN)))
        else $error("divider done outside a division state");

    // an accepted item always leaves idle on the next cycle
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != T_IDLE))
        else $error("sequencer stayed idle after accept");

endmodule

`default_nettype wire

// File: test/tb_fraction_gcd_reducer.sv
// Self-checking testbench for the fraction GCD reducer with random stalls on both channels.
`timescale 1ns / 1ps

module tb_fraction_gcd_reducer
    import fgr_pkg::*;
();

    localparam int   IDLE_PCT        = 24;
    localparam int   DRAIN_CYCLES    = 400;
    localparam int   STALL_LIMIT     = 5000;
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] den;
        logic               status;
    } fraction_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_numerator   = '0;
    logic [FIELD_W-1:0] s_denominator = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [FIELD_W-1:0] m_reduced_numerator;
    logic [FIELD_W-1:0] m_reduced_denominator;
    logic               m_status;

    fraction_t pending_fractions[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        idling_on      = 1'b1;

    fraction_gcd_reducer i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_numerator           (s_numerator),
        .s_denominator         (s_denominator),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_reduced_numerator   (m_reduced_numerator),
        .m_reduced_denominator (m_reduced_denominator),
        .m_status              (m_status)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Lowest terms by Euclid; operands are first cut to the arithmetic width.
    function automatic fraction_t reduce_fraction(input logic [FIELD_W-1:0] num_in,
                                                  input logic [FIELD_W-1:0] den_in);
        logic [63:0] width_mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        fraction_t   res;
        width_mask = (CALC_W >= 64) ? '1 : ((64'd1 << CALC_W) - 64'd1);
        a = {32'd0, num_in} & width_mask;
        b = {32'd0, den_in} & width_mask;
        if (b == 0) begin
            res = '{num: a[FIELD_W-1:0], den: '0, status: STATUS_ZERO_DEN};
        end else if (a == 0) begin
            res = '{num: '0, den: FIELD_W'(1), status: STATUS_REDUCED};
        end else begin
            res.num    = num_in & width_mask[FIELD_W-1:0];
            res.den    = den_in & width_mask[FIELD_W-1:0];
            res.status = STATUS_REDUCED;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            res.num = res.num / a[FIELD_W-1:0];
            res.den = res.den / a[FIELD_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                   input logic [FIELD_W-1:0] got);
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Called right after a rising edge; returns at the edge that accepts the item.
    // s_valid is left high so back-to-back items need no extra assignment.
    task automatic send_fraction(input logic [FIELD_W-1:0] num, input logic [FIELD_W-1:0] den);
        while (idling_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid       <= 1'b0;
            s_numerator   <= $urandom;
            s_denominator <= $urandom;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_numerator   <= num;
        s_denominator <= den;
        do @(posedge aclk); while (!s_ready);
        pending_fractions.push_back(reduce_fraction(num, den));
    endtask

    task automatic test_zero_denominator;
        send_fraction(32'd5, 32'd0);
        send_fraction(32'd0, 32'd0);
        send_fraction(ALL_ONES, 32'd0);
        send_fraction(32'h8000_0000, 32'd0);
    endtask

    task automatic test_zero_numerator;
        send_fraction(32'd0, 32'd1);
        send_fraction(32'd0, 32'd7);
        send_fraction(32'd0, ALL_ONES);
    endtask

    task automatic test_already_reduced;
        send_fraction(32'd1, 32'd1);
        send_fraction(32'd3, 32'd7);
        send_fraction(ALL_ONES, ALL_ONES - 1);
        send_fraction(32'd1, ALL_ONES);
        send_fraction(ALL_ONES, 32'd1);
    endtask

    task automatic test_common_factor;
        logic [FIELD_W-1:0] k;
        k = $urandom_range(1, 1000);
        send_fraction(32'd12, 32'd18);
        send_fraction(ALL_ONES, ALL_ONES);
        send_fraction(32'h8000_0000, 32'h4000_0000);
        send_fraction(ALL_ONES - 1, 32'd2);
        send_fraction(32'd6 * k, 32'd4 * k);
        send_fraction(32'h5555_5555, 32'hAAAA_AAAA);
        send_fraction(32'hFFFF_0000, 32'h0000_FFFF);
        send_fraction(32'd1_000_000_000, 32'd2_147_483_640);
    endtask

    // Half the fractions are built with a shared factor; the rest are plain noise and edge values.
    task automatic random_fraction(output logic [FIELD_W-1:0] num,
                                   output logic [FIELD_W-1:0] den);
        int                 pick;
        int                 gw;
        logic [FIELD_W-1:0] g;
        pick = $urandom_range(99);
        gw   = $urandom_range(1, 31);
        g    = $urandom >> (FIELD_W - gw);
        if (g == 0) g = 1;
        if (pick < 20) begin
            num = $urandom;
            den = $urandom;
        end else if (pick < 60) begin
            num = ($urandom >> gw) * g;
            den = ($urandom >> gw) * g;
        end else if (pick < 70) begin
            num = $urandom << $urandom_range(0, 31);
            den = $urandom << $urandom_range(0, 31);
        end else if (pick < 80) begin
            num = $urandom_range(0, 255);
            den = $urandom_range(0, 255);
        end else if (pick < 90) begin
            // one term divides the other
            num = g;
            den = g * ($urandom >> gw);
            if ($urandom_range(1)) begin
                num = den;
                den = g;
            end
        end else if (pick < 95) begin
            num = $urandom;
            den = '0;
        end else begin
            num = '0;
            den = $urandom;
        end
    endtask

    task automatic test_random_fractions(input int count);
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] den;
        repeat (count) begin
            random_fraction(num, den);
            send_fraction(num, den);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= idling_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge aclk) begin
        fraction_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_fractions.size() == 0) begin
                report_mismatch("result with nothing pending", '0, m_reduced_numerator);
            end else begin
                want = pending_fractions.pop_front();
                if (m_reduced_numerator !== want.num)
                    report_mismatch("reduced numerator", want.num, m_reduced_numerator);
                if (m_reduced_denominator !== want.den)
                    report_mismatch("reduced denominator", want.den, m_reduced_denominator);
                if (m_status !== want.status)
                    report_mismatch("status", FIELD_W'(want.status), FIELD_W'(m_status));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("fraction_gcd_reducer: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_denominator;
        test_zero_numerator;
        test_already_reduced;
        test_common_factor;
        test_random_fractions(700);
        idling_on = 1'b0;
        test_random_fractions(400);
        idling_on = 1'b1;
        test_random_fractions(700);
        s_valid <= 1'b0;

        while (pending_fractions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_fractions.size() != 0)
            report_mismatch("results never returned", '0, FIELD_W'(pending_fractions.size()));
        if (mismatch_count == 0) begin
            $display("fraction_gcd_reducer: match");
        end else begin
            $display("fraction_gcd_reducer: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/fgr_pkg.sv
src/fgr_gcd.sv
src/fgr_div.sv
src/fraction_gcd_reducer.sv
test/tb_fraction_gcd_reducer.sv
